/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lap_pkg.sv */
// ----------------------------------------------------------------------------
// lap_pkg
// Types and constants of the 3x3 four-neighbour Laplacian filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lap_pkg;

   localparam int PIX_W      = 8;
   localparam int MAX_WIDTH  = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 12;
   localparam int CFG_W      = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
   localparam logic [CFG_W-1:0] MIN_DIM      = CFG_W'(3);
   localparam logic [CFG_W-1:0] MAX_DIM      = CFG_W'(MAX_WIDTH);

   // Result queue: three entries keep one pixel per clock unless rsp_tready stalls it.
   localparam int               OUTQ_DEPTH = 3;
   localparam int               OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam logic [OUTQ_PTR_W-1:0] OUTQ_LAST_PTR = OUTQ_PTR_W'(OUTQ_DEPTH - 1);
   localparam int               OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   // Register index, taken from the word address on the configuration port.
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   // Line store word: upper row in the high byte, middle row in the low byte.
   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } line_word_type;

   // Pixel on its way from the read to the write-back of the line store.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] column;
      logic             produce;
      logic             last;
   } stage_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic             last;
   } result_type;

endpackage

/* src/laplacian_filter_3x3_top.sv */
// ----------------------------------------------------------------------------
// laplacian_filter_3x3_top
// Four-neighbour Laplacian over a raster-order 8-bit grayscale stream.
// ----------------------------------------------------------------------------
//   channel  | role            | payload
//   req_     | pixel in        | tdata[7:0] pixel
//   rsp_     | result out      | tdata[7:0] magnitude, tlast last interior result
//   csr_     | APB registers   | 0x0 image_width, 0x4 image_height
//
// One pixel per clock while req_tready is high. Each pixel reads its column of
// the line store on acceptance and writes it back the next cycle, so the single
// memory port pair sets the rate; results enter the queue from the read stage.
// Reset is synchronous; the line store is not cleared and needs none.
// A three-entry result queue absorbs output stalls; req_tready drops only
// when that queue and the pixel in flight would fill it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplacian_filter_3x3_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lap_pkg::PIX_W-1:0]           req_tdata,    // [7:0] pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lap_pkg::PIX_W-1:0]           rsp_tdata,    // [7:0] magnitude
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lap_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lap_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lap_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // ---------------- configuration registers ----------------
   logic [lap_pkg::CFG_W-1:0] width_ff, width_in;
   logic [lap_pkg::CFG_W-1:0] height_ff, height_in;
   logic                      csr_wr;
   lap_pkg::csr_reg_type      csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = lap_pkg::csr_reg_type'(csr_paddr[lap_pkg::CSR_ADDR_W-1]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            lap_pkg::REG_IMAGE_WIDTH:  width_in  = csr_pwdata[lap_pkg::CFG_W-1:0];
            lap_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[lap_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         lap_pkg::REG_IMAGE_WIDTH:
            csr_prdata = lap_pkg::CSR_DATA_W'(width_ff);
         lap_pkg::REG_IMAGE_HEIGHT:
            csr_prdata = lap_pkg::CSR_DATA_W'(height_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // Clamp the geometry to what the line store supports.
   logic [lap_pkg::CFG_W-1:0] eff_width, eff_height;

   always_comb begin
      if (width_ff < lap_pkg::MIN_DIM)       eff_width = lap_pkg::MIN_DIM;
      else if (width_ff > lap_pkg::MAX_DIM)  eff_width = lap_pkg::MAX_DIM;
      else                                   eff_width = width_ff;
      eff_height = (height_ff < lap_pkg::MIN_DIM) ? lap_pkg::MIN_DIM : height_ff;
   end

   // ---------------- raster counters, read stage ----------------
   logic [lap_pkg::COL_W-1:0] col_ff, col_in;
   logic [lap_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      accept;
   logic                      row_end, frame_end;
   lap_pkg::stage_type        s1_ff, s1_in;
   logic                      s1_valid_ff, s1_valid_in;

   assign accept    = req_tvalid && req_tready;
   assign row_end   = lap_pkg::CFG_W'(col_ff) >= (eff_width - lap_pkg::CFG_W'(1));
   assign frame_end = lap_pkg::CFG_W'(row_ff) >= (eff_height - lap_pkg::CFG_W'(1));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_in       = s1_ff;
      s1_valid_in = accept;
      if (accept) begin
         s1_in.pixel   = req_tdata;
         s1_in.column  = col_ff;
         s1_in.produce = (row_ff >= lap_pkg::ROW_W'(2)) && (col_ff >= lap_pkg::COL_W'(2));
         s1_in.last    = row_end && frame_end;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : lap_pkg::ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = lap_pkg::COL_W'(col_ff + 1'b1);
         end
      end
   end

   // ---------------- line store ----------------
   // Consecutive pixels always hit different columns (width is at least 3),
   // and a write-back lands in the cycle after its read, so no forwarding is needed.
   lap_pkg::line_word_type line_mem [lap_pkg::MAX_WIDTH];
   lap_pkg::line_word_type rd_word_ff;
   lap_pkg::line_word_type wr_word;

   assign wr_word.upper  = rd_word_ff.middle;
   assign wr_word.middle = s1_ff.pixel;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_ff.column] <= wr_word;
      end
   end

   // ---------------- window and kernel ----------------
   logic [lap_pkg::PIX_W-1:0] left_ff, left_in;     // centre row, column c-2
   logic [lap_pkg::PIX_W-1:0] up_ff, up_in;         // top row, column c-1
   logic [lap_pkg::PIX_W-1:0] centre_ff, centre_in; // centre row, column c-1
   logic [lap_pkg::PIX_W-1:0] down_ff, down_in;     // bottom row, column c-1
   logic [lap_pkg::PIX_W+1:0] neigh_sum;
   logic signed [lap_pkg::PIX_W+2:0] lap_val;
   logic [lap_pkg::PIX_W+2:0] lap_abs;
   lap_pkg::result_type       result;

   always_comb begin
      left_in   = left_ff;
      up_in     = up_ff;
      centre_in = centre_ff;
      down_in   = down_ff;
      if (s1_valid_ff) begin
         left_in   = centre_ff;
         up_in     = rd_word_ff.upper;
         centre_in = rd_word_ff.middle;
         down_in   = s1_ff.pixel;
      end
   end

   always_comb begin
      neigh_sum = (lap_pkg::PIX_W+2)'(up_ff) + (lap_pkg::PIX_W+2)'(down_ff)
                + (lap_pkg::PIX_W+2)'(left_ff) + (lap_pkg::PIX_W+2)'(rd_word_ff.middle);
      lap_val   = $signed({1'b0, neigh_sum}) - $signed({1'b0, centre_ff, 2'b00});
      lap_abs   = lap_val[lap_pkg::PIX_W+2] ? (lap_pkg::PIX_W+3)'(-lap_val)
                                            : (lap_pkg::PIX_W+3)'(lap_val);
      // Saturate at full scale.
      result.magnitude = (lap_abs[lap_pkg::PIX_W+2:lap_pkg::PIX_W] != '0)
                       ? {lap_pkg::PIX_W{1'b1}} : lap_abs[lap_pkg::PIX_W-1:0];
      result.last      = s1_ff.last;
   end

   // ---------------- result queue ----------------
   lap_pkg::result_type             outq_mem [lap_pkg::OUTQ_DEPTH];
   logic [lap_pkg::OUTQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lap_pkg::OUTQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lap_pkg::OUTQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [lap_pkg::OUTQ_CNT_W-1:0]  pending;
   logic                            push, pop;

   assign push       = s1_valid_ff && s1_ff.produce;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = outq_mem[rd_ptr_ff].magnitude;
   assign rsp_tlast  = outq_mem[rd_ptr_ff].last;

   // Leave room for the pixel in flight and the one accepted now.
   assign pending    = cnt_ff + lap_pkg::OUTQ_CNT_W'(s1_valid_ff);
   assign req_tready = pending < lap_pkg::OUTQ_CNT_W'(lap_pkg::OUTQ_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lap_pkg::OUTQ_LAST_PTR) ? '0
                   : lap_pkg::OUTQ_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lap_pkg::OUTQ_LAST_PTR) ? '0
                   : lap_pkg::OUTQ_PTR_W'(rd_ptr_ff + 1'b1);
      end
      unique case ({push, pop})
         2'b10:   cnt_in = lap_pkg::OUTQ_CNT_W'(cnt_ff + 1'b1);
         2'b01:   cnt_in = lap_pkg::OUTQ_CNT_W'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         outq_mem[wr_ptr_ff] <= result;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (reset) begin
         width_ff    <= lap_pkg::WIDTH_RESET;
         height_ff   <= lap_pkg::HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
         up_ff       <= '0;
         centre_ff   <= '0;
         down_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         left_ff     <= left_in;
         up_ff       <= up_in;
         centre_ff   <= centre_in;
         down_ff     <= down_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule

/* src/lap_checker.sv */
// ----------------------------------------------------------------------------
// lap_checker
// Port-level checks of the Laplacian filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lap_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_pready
);

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // Out of reset: nothing queued, input open.
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_tvalid && req_tready && csr_pready), "reset left the block busy")

   // A new result follows an input beat taken through the read stage and the result queue.
   `ASSERT_CLKD(a_result_has_source, clock, reset, $rose(rsp_tvalid) |-> $past(req_beat, 2), "result without a pixel behind it")

   // A stalled result holds.
   `ASSERT_CLKD(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "stalled result beat changed")

endmodule

bind laplacian_filter_3x3_top lap_checker u_lap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
